/* sv/lp2c_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lp2c_pkg
// Shared types, register indexes and CORDIC constants of the lidar beam
// polar-to-Cartesian converter.
// ----------------------------------------------------------------------------
package lp2c_pkg;

  localparam int unsigned MAX_BEAMS_DEF = 4096;
  localparam int unsigned CORDIC_STEPS  = 16;
  localparam int unsigned XW            = 27;  // x/y working width, 24 fraction bits
  localparam int unsigned ZW            = 18;  // residual angle width
  localparam int unsigned IDXW          = 12;
  localparam int unsigned SMPW          = 16;
  localparam int unsigned POSW          = 17;
  localparam int unsigned CFG_IDXW      = 3;
  localparam int unsigned CFG_DW        = 16;

  localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(10188014);

  typedef enum logic [CFG_IDXW-1:0] {
    REG_RANGE_LOW        = 3'd0,
    REG_RANGE_HIGH       = 3'd1,
    REG_ANGLE_START      = 3'd2,
    REG_ANGLE_STEP       = 3'd3,
    REG_INTENSITY_ENABLE = 3'd4
  } lp2c_reg_t;

  // Beam data that rides along the rotation chain.
  typedef struct packed {
    logic            flip;
    logic [SMPW-1:0] rng;
    logic [SMPW-1:0] inten;
    logic [IDXW-1:0] idx;
  } lp2c_side_t;

  // One slot of the rotation chain.
  typedef struct packed {
    logic                   valid;
    logic signed [XW-1:0]   x;
    logic signed [XW-1:0]   y;
    logic signed [ZW-1:0]   z;
    lp2c_side_t             side;
  } lp2c_vec_t;

  // Arctangent of 2^-i in binary angle units (full circle 65536).
  function automatic logic [13:0] atan_binang(input int unsigned i);
    logic [13:0] a;
    case (i)
      0:       a = 14'd8192;
      1:       a = 14'd4836;
      2:       a = 14'd2555;
      3:       a = 14'd1297;
      4:       a = 14'd651;
      5:       a = 14'd326;
      6:       a = 14'd163;
      7:       a = 14'd81;
      8:       a = 14'd41;
      9:       a = 14'd20;
      10:      a = 14'd10;
      11:      a = 14'd5;
      12:      a = 14'd3;
      13:      a = 14'd1;
      14:      a = 14'd1;
      default: a = 14'd0;
    endcase
    return a;
  endfunction

endpackage

/* sv/lp2c_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lp2c_front
// Entry stage: range and index filter, beam angle, quadrant fold and the
// seed vector of the rotation chain.
// ----------------------------------------------------------------------------
module lp2c_front
  import lp2c_pkg::*;
#(
  parameter int unsigned MAX_BEAMS = MAX_BEAMS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_valid,
  input  logic [IDXW-1:0] in_beam_index,
  input  logic [SMPW-1:0] in_range_sample,
  input  logic [SMPW-1:0] in_intensity_sample,
  input  logic [SMPW-1:0] range_low,
  input  logic [SMPW-1:0] range_high,
  input  logic [15:0]     angle_start,
  input  logic [15:0]     angle_step,
  input  logic            intensity_enable,
  output lp2c_vec_t       vec_o
);

  logic [IDXW+15:0] prod;
  logic [15:0]      ang;
  logic             flip;
  logic             keep;
  lp2c_vec_t        vec_r;
  lp2c_vec_t        vec_nxt;

  always_comb begin
    prod = (IDXW+16)'(in_beam_index) * (IDXW+16)'(angle_step);
    ang  = angle_start + prod[15:0];
    // fold into a quarter turn either side of zero
    flip = ang[15] ^ ang[14];
    keep = in_valid && (32'(in_beam_index) < MAX_BEAMS) &&
           (in_range_sample >= range_low) && (in_range_sample <= range_high);

    vec_nxt.valid      = keep;
    vec_nxt.x          = CORDIC_GAIN;
    vec_nxt.y          = '0;
    vec_nxt.z          = ZW'($signed({ang[15] ^ flip, ang[14:0]}));
    vec_nxt.side.flip  = flip;
    vec_nxt.side.rng   = in_range_sample;
    vec_nxt.side.inten = intensity_enable ? in_intensity_sample : '0;
    vec_nxt.side.idx   = in_beam_index;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec_r.valid <= 1'b0;
    end else if (adv) begin
      vec_r <= vec_nxt;
    end
  end

  assign vec_o = vec_r;

endmodule

/* sv/lp2c_cordic_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lp2c_cordic_cell
// One CORDIC rotation toward zero residual angle, registered.
// ----------------------------------------------------------------------------
module lp2c_cordic_cell
  import lp2c_pkg::*;
#(
  parameter int unsigned STEP = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  lp2c_vec_t vec_i,
  output lp2c_vec_t vec_o
);

  logic signed [XW-1:0] xi;
  logic signed [XW-1:0] yi;
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [ZW-1:0] zi;
  logic signed [ZW-1:0] da;
  lp2c_vec_t            vec_r;
  lp2c_vec_t            vec_nxt;

  always_comb begin
    xi = vec_i.x;
    yi = vec_i.y;
    zi = vec_i.z;
    dx = yi >>> STEP;
    dy = xi >>> STEP;
    da = $signed(ZW'(atan_binang(STEP)));
    vec_nxt = vec_i;
    if (!zi[ZW-1]) begin
      vec_nxt.x = xi - dx;
      vec_nxt.y = yi + dy;
      vec_nxt.z = zi - da;
    end else begin
      vec_nxt.x = xi + dx;
      vec_nxt.y = yi - dy;
      vec_nxt.z = zi + da;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec_r.valid <= 1'b0;
    end else if (adv) begin
      vec_r <= vec_nxt;
    end
  end

  assign vec_o = vec_r;

endmodule

/* sv/lp2c_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lp2c_back
// Round and clamp cos/sin to Q1.15, undo the fold, scale by range and hold
// the result beat in the output register.
// ----------------------------------------------------------------------------
module lp2c_back
  import lp2c_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  lp2c_vec_t              vec_i,
  output logic                   out_valid,
  output logic signed [POSW-1:0] out_x_pos,
  output logic signed [POSW-1:0] out_y_pos,
  output logic [SMPW-1:0]        out_intensity_out,
  output logic [IDXW-1:0]        out_beam_index_out
);

  localparam logic signed [XW-1:0] RND_Q15 = XW'(256);
  localparam logic signed [XW-1:0] LIM_Q15 = XW'(32767);

  logic signed [XW-1:0] xi;
  logic signed [XW-1:0] yi;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [15:0]   cq;
  logic signed [15:0]   sq;
  logic signed [15:0]   c_nxt;
  logic signed [15:0]   s_nxt;

  logic                 tv_r;
  logic signed [15:0]   c_r;
  logic signed [15:0]   s_r;
  logic [SMPW-1:0]      rng_r;
  logic [SMPW-1:0]      inten_r;
  logic [IDXW-1:0]      idx_r;

  logic signed [32:0]   px;
  logic signed [32:0]   py;
  logic signed [32:0]   rx;
  logic signed [32:0]   ry;

  logic                   ov_r;
  logic signed [POSW-1:0] x_r;
  logic signed [POSW-1:0] y_r;
  logic [SMPW-1:0]        oi_r;
  logic [IDXW-1:0]        oidx_r;

  function automatic logic signed [15:0] clamp_q15(input logic signed [XW-1:0] v);
    logic signed [15:0] r;
    if (v > LIM_Q15) begin
      r = 16'sd32767;
    end else if (v < -LIM_Q15) begin
      r = -16'sd32767;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  always_comb begin
    xi    = vec_i.x;
    yi    = vec_i.y;
    xs    = (xi + RND_Q15) >>> 9;
    ys    = (yi + RND_Q15) >>> 9;
    cq    = clamp_q15(xs);
    sq    = clamp_q15(ys);
    c_nxt = vec_i.side.flip ? -cq : cq;
    s_nxt = vec_i.side.flip ? -sq : sq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (adv) begin
      tv_r <= vec_i.valid;
      ov_r <= tv_r;
    end
  end

  always_comb begin
    px = $signed({17'b0, rng_r}) * 33'(c_r);
    py = $signed({17'b0, rng_r}) * 33'(s_r);
    rx = (px + 33'sd16384) >>> 15;
    ry = (py + 33'sd16384) >>> 15;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_r     <= c_nxt;
      s_r     <= s_nxt;
      rng_r   <= vec_i.side.rng;
      inten_r <= vec_i.side.inten;
      idx_r   <= vec_i.side.idx;
      x_r     <= rx[POSW-1:0];
      y_r     <= ry[POSW-1:0];
      oi_r    <= inten_r;
      oidx_r  <= idx_r;
    end
  end

  assign out_valid          = ov_r;
  assign out_x_pos          = x_r;
  assign out_y_pos          = y_r;
  assign out_intensity_out  = oi_r;
  assign out_beam_index_out = oidx_r;

endmodule

/* sv/lidar_polar_to_cartesian.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_polar_to_cartesian
// Converts lidar beams (index, Q8.8 range, intensity) into Cartesian points
// through a chain of CORDIC rotation cells.
// ----------------------------------------------------------------------------
// Takes one beam beat per clock and delivers one point beat per clock while
// not stalled, through one entry stage (filter, angle multiply, fold), sixteen
// rotation cells, one rounding stage and one scaling stage that also serves as
// output register. Beams whose range falls outside
// [range_low, range_high], or whose index is not below MAX_BEAMS, leave a
// bubble in the chain and produce no point. The whole chain advances together;
// while a finished point waits under out_stall, the chain holds and in_stall
// is raised. A bubble that reaches the output never holds the chain, even
// under out_stall. Write configuration only while no beam is in flight.
// ----------------------------------------------------------------------------
module lidar_polar_to_cartesian
  import lp2c_pkg::*;
#(
  parameter int unsigned MAX_BEAMS = MAX_BEAMS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // beam input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [IDXW-1:0]        in_beam_index,
  input  logic [SMPW-1:0]        in_range_sample,
  input  logic [SMPW-1:0]        in_intensity_sample,
  // point output channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [POSW-1:0] out_x_pos,
  output logic signed [POSW-1:0] out_y_pos,
  output logic [SMPW-1:0]        out_intensity_out,
  output logic [IDXW-1:0]        out_beam_index_out,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_IDXW-1:0]    cfg_index,
  input  logic [CFG_DW-1:0]      cfg_wdata
);

  logic [SMPW-1:0] range_low_r;
  logic [SMPW-1:0] range_high_r;
  logic [15:0]     angle_start_r;
  logic [15:0]     angle_step_r;
  logic            intensity_enable_r;

  logic      adv;
  lp2c_vec_t chain [0:CORDIC_STEPS];

  // Configuration registers; indexes off the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r        <= '0;
      range_high_r       <= '1;
      angle_start_r      <= '0;
      angle_step_r       <= '0;
      intensity_enable_r <= 1'b0;
    end else if (cfg_we) begin
      case (lp2c_reg_t'(cfg_index))
        REG_RANGE_LOW:        range_low_r        <= cfg_wdata;
        REG_RANGE_HIGH:       range_high_r       <= cfg_wdata;
        REG_ANGLE_START:      angle_start_r      <= cfg_wdata;
        REG_ANGLE_STEP:       angle_step_r       <= cfg_wdata;
        REG_INTENSITY_ENABLE: intensity_enable_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Advance the whole chain unless a point is held at the output.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  lp2c_front #(
    .MAX_BEAMS (MAX_BEAMS)
  ) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .adv                 (adv),
    .in_valid            (in_valid),
    .in_beam_index       (in_beam_index),
    .in_range_sample     (in_range_sample),
    .in_intensity_sample (in_intensity_sample),
    .range_low           (range_low_r),
    .range_high          (range_high_r),
    .angle_start         (angle_start_r),
    .angle_step          (angle_step_r),
    .intensity_enable    (intensity_enable_r),
    .vec_o               (chain[0])
  );

  // One rotation cell per CORDIC step, each handing its vector on.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    lp2c_cordic_cell #(
      .STEP (i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .vec_i (chain[i]),
      .vec_o (chain[i+1])
    );
  end

  lp2c_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .adv                (adv),
    .vec_i              (chain[CORDIC_STEPS]),
    .out_valid          (out_valid),
    .out_x_pos          (out_x_pos),
    .out_y_pos          (out_y_pos),
    .out_intensity_out  (out_intensity_out),
    .out_beam_index_out (out_beam_index_out)
  );

endmodule

/* tb/lidar_polar_to_cartesian_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_polar_to_cartesian_tb
// Self-checking bench for the beam-to-point converter: a CORDIC predictor
// tracks every beam the block takes and compares each point it delivers.
// ----------------------------------------------------------------------------
module lidar_polar_to_cartesian_tb
  import lp2c_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either channel
  localparam int POST_DRAIN     = 24;    // pipeline is 19 deep; leave some margin
  localparam int RANDOM_PHASES  = 8;
  localparam int BEAMS_PER_PHASE = 75;

  // Register indexes beyond the list; writes there must be ignored.
  localparam logic [CFG_IDXW-1:0] SPARE_REG_FIRST = 3'd5;
  localparam logic [CFG_IDXW-1:0] SPARE_REG_LAST  = 3'd7;

  // Arctangent of 2^-i, binary angle units (65536 per turn).
  localparam int ARC_STEP [CORDIC_STEPS] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                              41, 20, 10, 5, 3, 1, 1, 0};

  typedef struct packed {
    logic signed [POSW-1:0] x;
    logic signed [POSW-1:0] y;
    logic [SMPW-1:0]        inten;
    logic [IDXW-1:0]        idx;
  } point_t;

  // Holds a private copy of the registers and the points still owed by the block.
  class point_ledger;
    logic [SMPW-1:0] range_low;
    logic [SMPW-1:0] range_high;
    logic [15:0]     angle_start;
    logic [15:0]     angle_step;
    logic            intensity_on;
    point_t          pending_points[$];
    int              failures;
    int              beams_seen;
    int              beams_dropped;
    int              points_checked;

    function new();
      range_low    = '0;
      range_high   = '1;
      angle_start  = '0;
      angle_step   = '0;
      intensity_on = 1'b0;
    endfunction

    function void set_reg(logic [CFG_IDXW-1:0] idx, logic [CFG_DW-1:0] data);
      case (idx)
        REG_RANGE_LOW:        range_low    = data;
        REG_RANGE_HIGH:       range_high   = data;
        REG_ANGLE_START:      angle_start  = data;
        REG_ANGLE_STEP:       angle_step   = data;
        REG_INTENSITY_ENABLE: intensity_on = data[0];
        default: ;
      endcase
    endfunction

    // Fold to [-1/4, +1/4) turn, rotate, round to Q1.15, clamp and undo the fold.
    function void cordic_cos_sin(logic [15:0] ang, output int c, output int s);
      int x, y, z, dx, dy;
      bit flip;
      x = 10188014;
      y = 0;
      z = int'(ang);
      flip = 1'b0;
      if (ang[15:14] == 2'b01 || ang[15:14] == 2'b10) begin
        z -= 32768;
        flip = 1'b1;
      end else if (ang[15:14] == 2'b11) begin
        z -= 65536;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= ARC_STEP[i];
        end else begin
          x += dx; y -= dy; z += ARC_STEP[i];
        end
      end
      c = (x + 256) >>> 9;
      s = (y + 256) >>> 9;
      if (c > 32767) c = 32767;
      if (c < -32767) c = -32767;
      if (s > 32767) s = 32767;
      if (s < -32767) s = -32767;
      if (flip) begin
        c = -c;
        s = -s;
      end
    endfunction

    function void note_beam(logic [IDXW-1:0] idx, logic [SMPW-1:0] rng,
                            logic [SMPW-1:0] inten);
      logic [15:0] ang;
      int          c, s;
      longint      xp, yp;
      point_t      pt;
      beams_seen++;
      if (idx >= MAX_BEAMS_DEF || rng < range_low || rng > range_high) begin
        beams_dropped++;
        return;
      end
      ang = angle_start + 16'(idx) * angle_step;
      cordic_cos_sin(ang, c, s);
      xp = (longint'(rng) * c + 16384) >>> 15;
      yp = (longint'(rng) * s + 16384) >>> 15;
      pt.x     = xp[POSW-1:0];
      pt.y     = yp[POSW-1:0];
      pt.inten = intensity_on ? inten : '0;
      pt.idx   = idx;
      pending_points.insert(pending_points.size(), pt);
    endfunction

    function void check_point(logic signed [POSW-1:0] x, logic signed [POSW-1:0] y,
                              logic [SMPW-1:0] inten, logic [IDXW-1:0] idx);
      point_t want;
      if (pending_points.size() == 0) begin
        $error("point for beam %0d arrived with no beam pending", idx);
        failures++;
        return;
      end
      want = pending_points.pop_front();
      points_checked++;
      if (x !== want.x) begin
        $error("x_pos: expected %0d, got %0d", want.x, x);
        failures++;
      end
      if (y !== want.y) begin
        $error("y_pos: expected %0d, got %0d", want.y, y);
        failures++;
      end
      if (inten !== want.inten) begin
        $error("intensity_out: expected %0d, got %0d", want.inten, inten);
        failures++;
      end
      if (idx !== want.idx) begin
        $error("beam_index_out: expected %0d, got %0d", want.idx, idx);
        failures++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [IDXW-1:0]        in_beam_index = '0;
  logic [SMPW-1:0]        in_range_sample = '0;
  logic [SMPW-1:0]        in_intensity_sample = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic signed [POSW-1:0] out_x_pos;
  logic signed [POSW-1:0] out_y_pos;
  logic [SMPW-1:0]        out_intensity_out;
  logic [IDXW-1:0]        out_beam_index_out;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDXW-1:0]    cfg_index = '0;
  logic [CFG_DW-1:0]      cfg_wdata = '0;

  point_ledger ledger = new();
  int          send_gap_pct = 0;   // chance per beat that the sender idles
  int          stall_pct    = 0;   // chance per cycle that the receiver stalls
  int          quiet_cycles = 0;
  int          settings_used = 1;  // reset values count as the first setting

  lidar_polar_to_cartesian uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_beam_index       (in_beam_index),
    .in_range_sample     (in_range_sample),
    .in_intensity_sample (in_intensity_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_x_pos           (out_x_pos),
    .out_y_pos           (out_y_pos),
    .out_intensity_out   (out_intensity_out),
    .out_beam_index_out  (out_beam_index_out),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Receiver back-pressure: one fresh coin flip per cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Log every beam beat the block takes; the predictor decides if a point is owed.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      ledger.note_beam(in_beam_index, in_range_sample, in_intensity_sample);
  end

  // Compare every point beat against the oldest owed point.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      ledger.check_point(out_x_pos, out_y_pos, out_intensity_out, out_beam_index_out);
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d quiet cycles, %0d points still owed",
                 quiet_cycles, ledger.pending_points.size());
        $display("lidar_polar_to_cartesian: mismatch");
        $finish;
      end
    end
  end

  // Offer one beam, with random idle cycles ahead of it, and hold it until taken.
  task automatic send_beam(logic [IDXW-1:0] idx, logic [SMPW-1:0] rng,
                           logic [SMPW-1:0] inten);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_beam_index       <= idx;
    in_range_sample     <= rng;
    in_intensity_sample <= inten;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid, wait for every owed point, then let trailing dropped beams clear.
  task automatic drain_points();
    in_valid <= 1'b0;
    while (ledger.pending_points.size() != 0) @(posedge clk);
    repeat (POST_DRAIN) @(posedge clk);
  endtask

  // Write one register; the caller lowers the write enable after the batch.
  task automatic write_reg(logic [CFG_IDXW-1:0] idx, logic [CFG_DW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    ledger.set_reg(idx, data);
  endtask

  // Load a full register set plus one write to an unused index, which must not stick.
  // The enable word may carry junk above bit zero; the random phases pass a random word.
  task automatic program_regs(logic [15:0] low, logic [15:0] high, logic [15:0] start,
                              logic [15:0] step, logic [15:0] enable_word);
    write_reg(REG_RANGE_LOW, low);
    write_reg(REG_RANGE_HIGH, high);
    write_reg(REG_ANGLE_START, start);
    write_reg(REG_ANGLE_STEP, step);
    write_reg(REG_INTENSITY_ENABLE, enable_word);
    write_reg(CFG_IDXW'($urandom_range(SPARE_REG_LAST, SPARE_REG_FIRST)),
              CFG_DW'($urandom));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Angle register value, biased toward the extremes and the trivial step.
  function automatic logic [15:0] pick_angle();
    case ($urandom_range(5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    logic [IDXW-1:0] idx;
    logic [SMPW-1:0] rng, low, high;

    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset registers: angle zero everywhere, intensity masked, nothing filtered.
    send_beam(12'd0, 16'h0000, 16'hFFFF);
    send_beam(12'd4095, 16'hFFFF, 16'h0001);
    send_beam(12'h555, 16'h8000, 16'hAAAA);
    drain_points();

    // Step of 16 puts beams 1024, 2048 and 3072 right on the quadrant edges;
    // probe both sides of each range bound.
    program_regs(16'h0100, 16'hF000, 16'h0000, 16'd16, 16'h0001);
    send_beam(12'd0, 16'h00FF, 16'h1234);     // just under the low bound
    send_beam(12'd0, 16'h0100, 16'h0000);     // on the low bound
    send_beam(12'd512, 16'hF000, 16'hFFFF);   // on the high bound, 45 degrees
    send_beam(12'd512, 16'hF001, 16'h5555);   // just over the high bound
    send_beam(12'd1023, 16'h8000, 16'h0F0F);
    send_beam(12'd1024, 16'h8000, 16'hF0F0);
    send_beam(12'd1025, 16'h8000, 16'h00FF);
    send_beam(12'd2047, 16'hEFFF, 16'hFF00);
    send_beam(12'd2048, 16'hEFFF, 16'h8001);
    send_beam(12'd3072, 16'h4321, 16'h7FFE);
    send_beam(12'd3584, 16'h4321, 16'h0002);
    send_beam(12'd4095, 16'hF000, 16'hFFFF);
    send_beam(12'hAAA, 16'h0101, 16'h0001);
    drain_points();

    // Inverted bounds: every beam must vanish.
    program_regs(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h0001);
    send_beam(12'd0, 16'h8000, 16'h1111);
    send_beam(12'd100, 16'h7FFF, 16'h2222);
    send_beam(12'd4095, 16'h0000, 16'h3333);
    drain_points();

    // Random scans: mostly consecutive indexes with in-window ranges, some
    // jumps, bound hits and out-of-window noise. Cycle through four mixes of
    // sender gaps and receiver stalls so bubbles land on every pipeline stage.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0) begin
        low  = 16'h0000;
        high = 16'hFFFF;
      end else begin
        low  = ($urandom_range(2) == 0) ? 16'h0000 : 16'($urandom_range(16'h3000));
        high = ($urandom_range(2) == 0) ? 16'hFFFF : 16'($urandom_range(16'hFFFF, 16'hD000));
      end
      program_regs(low, high, pick_angle(), pick_angle(), 16'($urandom));
      case (ph % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 62; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 62; end
        default: begin send_gap_pct = 13; stall_pct = 13; end
      endcase
      idx = IDXW'($urandom);
      repeat (BEAMS_PER_PHASE) begin
        if ($urandom_range(4) == 0) idx = IDXW'($urandom);
        else idx = idx + 1'b1;
        case ($urandom_range(19))
          0:       rng = low;
          1:       rng = high;
          2, 3:    rng = SMPW'($urandom);
          default: rng = SMPW'($urandom_range(high, low));
        endcase
        send_beam(idx, rng, SMPW'($urandom));
      end
      drain_points();
    end

    $display("covered %0d beams (%0d filtered out) over %0d register settings,",
             ledger.beams_seen, ledger.beams_dropped, settings_used);
    $display("%0d points compared under four gap/stall mixes, %0d failures",
             ledger.points_checked, ledger.failures);
    if (ledger.failures == 0 && ledger.pending_points.size() == 0)
      $display("lidar_polar_to_cartesian: match");
    else
      $display("lidar_polar_to_cartesian: mismatch");
    $finish;
  end

endmodule

/* lidar_polar_to_cartesian.f */
sv/lp2c_pkg.sv
sv/lp2c_front.sv
sv/lp2c_cordic_cell.sv
sv/lp2c_back.sv
sv/lidar_polar_to_cartesian.sv
tb/lidar_polar_to_cartesian_tb.sv
